// ===== sv/csf_pkg.sv =====
`timescale 1ns / 1ps
package csf_pkg;

	typedef struct packed {
		logic adv;
		logic valid;
	} csf_ctl_t;

	localparam int FLAG_W = 3;

endpackage

// ===== sv/csf_div.sv =====
`timescale 1ns / 1ps
module csf_div #(
	parameter int MW = 50,
	parameter int DW = 50,
	parameter int CW = 24,
	parameter int QB = 40
) (
	input  logic                clk,
	input  logic                arst_n,
	input  csf_pkg::csf_ctl_t   ctl,
	input  logic [MW-1:0]       mag0,
	input  logic [MW-1:0]       mag1,
	input  logic [DW-1:0]       den,
	output logic                valid_out,
	output logic [QB-1:0]       q0,
	output logic [QB-1:0]       q1
);
	import csf_pkg::*;

	localparam int RW = DW + 1;
	localparam int RF = QB - CW;

	logic [RW-1:0] rem_s [QB][2];
	logic [QB-1:0] low_s [QB][2];
	logic [QB-1:0] quo_s [QB][2];
	logic [DW-1:0] den_s [QB];
	logic          vld_s [QB];

	genvar k;
	generate
		for (k = 0; k < QB; k++) begin : g_stage
			logic [RW-1:0] rem_p [2];
			logic [QB-1:0] low_p [2];
			logic [QB-1:0] quo_p [2];
			logic [DW-1:0] den_p;
			logic          vld_p;
			logic [RW-1:0] rem_n [2];
			logic [QB-1:0] low_n [2];
			logic [QB-1:0] quo_n [2];

			if (k == 0) begin : g_first
				always_comb begin
					rem_p[0] = RW'(mag0 >> CW);
					rem_p[1] = RW'(mag1 >> CW);
					low_p[0] = QB'(mag0[CW-1:0]) << RF;
					low_p[1] = QB'(mag1[CW-1:0]) << RF;
					quo_p[0] = '0;
					quo_p[1] = '0;
					den_p    = den;
					vld_p    = ctl.valid;
				end
			end else begin : g_next
				always_comb begin
					rem_p = rem_s[k-1];
					low_p = low_s[k-1];
					quo_p = quo_s[k-1];
					den_p = den_s[k-1];
					vld_p = vld_s[k-1];
				end
			end

			always_comb begin
				logic [RW-1:0] r2;
				logic          ge;
				for (int j = 0; j < 2; j++) begin
					r2       = {rem_p[j][RW-2:0], low_p[j][QB-1]};
					ge       = r2 >= RW'(den_p);
					rem_n[j] = ge ? r2 - RW'(den_p) : r2;
					low_n[j] = low_p[j] << 1;
					quo_n[j] = {quo_p[j][QB-2:0], ge};
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (ctl.adv) begin
					vld_s[k] <= vld_p;
				end
			end

			always_ff @(posedge clk) begin
				if (ctl.adv) begin
					rem_s[k] <= rem_n;
					low_s[k] <= low_n;
					quo_s[k] <= quo_n;
					den_s[k] <= den_p;
				end
			end
		end
	endgenerate

	assign valid_out = vld_s[QB-1];
	assign q0        = quo_s[QB-1][0];
	assign q1        = quo_s[QB-1][1];

endmodule

// ===== sv/collinear_segment_fuse.sv =====
`timescale 1ns / 1ps
// registers from input word to output word: stages s1 to s4, the ratio divider, then s5 to s9;
// the ratio divider takes one quotient bit per stage
// throughput: one word per cycle, the whole pipeline advances unless the output is stalled
// reset: asynchronous, active low; clears all stage valid bits, no words in flight
module collinear_segment_fuse #(
	parameter int COORD_WIDTH     = 24,
	parameter int RATIO_FRAC_BITS = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_axis_tvalid,
	output logic                                     s_axis_tready,
	// base_start_x, base_start_y, base_end_x, base_end_y,
	// cand_start_x, cand_start_y, cand_end_x, cand_end_y
	input  logic [((8*COORD_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
	output logic                                     m_axis_tvalid,
	input  logic                                     m_axis_tready,
	// out_start_x, out_start_y, out_end_x, out_end_y
	output logic [((4*COORD_WIDTH+7)/8)*8-1:0]       m_axis_tdata,
	// fused, degenerate, saturated
	output logic [csf_pkg::FLAG_W-1:0]               m_axis_tuser
);
	import csf_pkg::*;

	localparam int CW   = COORD_WIDTH;
	localparam int RF   = RATIO_FRAC_BITS;
	localparam int VW   = CW + 1;
	localparam int PW   = 2 * VW;
	localparam int DENW = 2 * VW;
	localparam int NW   = 2 * VW + 1;
	localparam int MW   = NW - 1;
	localparam int CLW  = NW + CW + 1;
	localparam int QB   = CW + RF;
	localparam int ZW   = QB + 2;
	localparam int ZL   = ZW / 2;
	localparam int ZH   = ZW - ZL;
	localparam int PLW  = VW + ZL + 1;
	localparam int PHW  = VW + ZH;
	localparam int TW   = VW + ZW + 1;
	localparam int RESW = TW - RF + 1;
	localparam int ODW  = ((4*COORD_WIDTH+7)/8)*8;

	typedef struct packed {
		logic signed [CW-1:0] s0x;
		logic signed [CW-1:0] s0y;
		logic signed [CW-1:0] s1x;
		logic signed [CW-1:0] s1y;
		logic signed [VW-1:0] vx;
		logic signed [VW-1:0] vy;
		logic                 fused;
		logic                 degen;
		logic [1:0]           neg;
		logic [1:0]           clamp;
	} side_t;

	logic     adv;
	csf_ctl_t div_ctl;

	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	logic signed [CW-1:0] fin [8];
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			fin[i] = s_axis_tdata[i*CW +: CW];
		end
	end

	// s1: differences
	logic                 vld_s1;
	logic signed [CW-1:0] s0x_s1, s0y_s1, s1x_s1, s1y_s1;
	logic signed [VW-1:0] vx_s1, vy_s1, d0x_s1, d0y_s1, d1x_s1, d1y_s1;
	// s2: products
	logic                 vld_s2;
	logic signed [CW-1:0] s0x_s2, s0y_s2, s1x_s2, s1y_s2;
	logic signed [VW-1:0] vx_s2, vy_s2;
	logic signed [PW-1:0] vxx_s2, vyy_s2, a0x_s2, a0y_s2, a1x_s2, a1y_s2;
	// s3: dot products
	logic                 vld_s3;
	logic signed [CW-1:0] s0x_s3, s0y_s3, s1x_s3, s1y_s3;
	logic signed [VW-1:0] vx_s3, vy_s3;
	logic [DENW-1:0]      den_s3;
	logic signed [NW-1:0] n0_s3, n1_s3;
	// s4: range tests and magnitudes
	logic                 vld_s4;
	side_t                side_s4;
	logic [MW-1:0]        mag0_s4, mag1_s4;
	logic [DENW-1:0]      den_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_axis_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	logic signed [NW-1:0]  n_s3 [2];
	logic signed [CLW-1:0] dsh;
	logic [1:0]            in_rng, clamp_c, neg_c;
	logic [MW-1:0]         mag_c [2];
	logic                  degen_c;

	always_comb begin
		logic signed [CLW-1:0] ne;
		logic signed [NW-1:0]  nn;
		n_s3[0] = n0_s3;
		n_s3[1] = n1_s3;
		degen_c = den_s3 == '0;
		dsh     = $signed(CLW'(den_s3)) <<< CW;
		for (int j = 0; j < 2; j++) begin
			ne         = CLW'(n_s3[j]);
			nn         = -n_s3[j];
			neg_c[j]   = n_s3[j][NW-1];
			in_rng[j]  = !n_s3[j][NW-1] && (n_s3[j] <= $signed(NW'(den_s3)));
			clamp_c[j] = (ne >= dsh) || ((ne + dsh) <= $signed(CLW'(0)));
			mag_c[j]   = neg_c[j] ? MW'(nn) : MW'(n_s3[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s0x_s1 <= fin[0];
			s0y_s1 <= fin[1];
			s1x_s1 <= fin[2];
			s1y_s1 <= fin[3];
			vx_s1  <= VW'(fin[2]) - VW'(fin[0]);
			vy_s1  <= VW'(fin[3]) - VW'(fin[1]);
			d0x_s1 <= VW'(fin[4]) - VW'(fin[0]);
			d0y_s1 <= VW'(fin[5]) - VW'(fin[1]);
			d1x_s1 <= VW'(fin[6]) - VW'(fin[0]);
			d1y_s1 <= VW'(fin[7]) - VW'(fin[1]);

			s0x_s2 <= s0x_s1;
			s0y_s2 <= s0y_s1;
			s1x_s2 <= s1x_s1;
			s1y_s2 <= s1y_s1;
			vx_s2  <= vx_s1;
			vy_s2  <= vy_s1;
			vxx_s2 <= vx_s1 * vx_s1;
			vyy_s2 <= vy_s1 * vy_s1;
			a0x_s2 <= vx_s1 * d0x_s1;
			a0y_s2 <= vy_s1 * d0y_s1;
			a1x_s2 <= vx_s1 * d1x_s1;
			a1y_s2 <= vy_s1 * d1y_s1;

			s0x_s3 <= s0x_s2;
			s0y_s3 <= s0y_s2;
			s1x_s3 <= s1x_s2;
			s1y_s3 <= s1y_s2;
			vx_s3  <= vx_s2;
			vy_s3  <= vy_s2;
			den_s3 <= DENW'(vxx_s2 + vyy_s2);
			n0_s3  <= NW'(a0x_s2) + NW'(a0y_s2);
			n1_s3  <= NW'(a1x_s2) + NW'(a1y_s2);

			side_s4.s0x   <= s0x_s3;
			side_s4.s0y   <= s0y_s3;
			side_s4.s1x   <= s1x_s3;
			side_s4.s1y   <= s1y_s3;
			side_s4.vx    <= vx_s3;
			side_s4.vy    <= vy_s3;
			side_s4.degen <= degen_c;
			side_s4.fused <= !degen_c && (in_rng[0] || in_rng[1]);
			side_s4.neg   <= neg_c;
			side_s4.clamp <= clamp_c;
			mag0_s4       <= mag_c[0];
			mag1_s4       <= mag_c[1];
			den_s4        <= den_s3;
		end
	end

	// ratio divider, side data delayed alongside
	logic          div_vld;
	logic [QB-1:0] q0, q1;

	assign div_ctl.adv   = adv;
	assign div_ctl.valid = vld_s4;

	csf_div #(
		.MW(MW),
		.DW(DENW),
		.CW(CW),
		.QB(QB)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.mag0     (mag0_s4),
		.mag1     (mag1_s4),
		.den      (den_s4),
		.valid_out(div_vld),
		.q0       (q0),
		.q1       (q1)
	);

	side_t side_d_s [QB];

	always_ff @(posedge clk) begin
		if (adv) begin
			side_d_s[0] <= side_s4;
			for (int k = 1; k < QB; k++) begin
				side_d_s[k] <= side_d_s[k-1];
			end
		end
	end

	// s5: signed ratios, s6: span, s7: partial products, s8: sums, s9: output
	logic                 vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	side_t                side_s5, side_s6, side_s7, side_s8;
	logic signed [ZW-1:0] z_s5 [2];
	logic signed [ZW-1:0] zlo_s6, zhi_s6;
	logic signed [PLW-1:0] pl_s7 [4];
	logic signed [PHW-1:0] ph_s7 [4];
	logic signed [TW-1:0]  t_s8 [4];

	logic signed [ZW-1:0] zc [2];
	logic [QB-1:0]        qv [2];
	always_comb begin
		logic signed [ZW-1:0] zm;
		qv[0] = q0;
		qv[1] = q1;
		for (int j = 0; j < 2; j++) begin
			zm    = side_d_s[QB-1].clamp[j] ? $signed(ZW'(1) <<< QB) : $signed(ZW'(qv[j]));
			zc[j] = side_d_s[QB-1].neg[j] ? -zm : zm;
		end
	end

	logic signed [ZW-1:0] zlo_c, zhi_c;
	always_comb begin
		zlo_c = '0;
		zhi_c = $signed(ZW'(1) <<< RF);
		for (int j = 0; j < 2; j++) begin
			if (z_s5[j] < zlo_c) begin
				zlo_c = z_s5[j];
			end
			if (z_s5[j] > zhi_c) begin
				zhi_c = z_s5[j];
			end
		end
	end

	logic signed [VW-1:0] vsel [4];
	logic signed [ZW-1:0] zsel [4];
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			vsel[j] = j[0] ? side_s6.vy : side_s6.vx;
			zsel[j] = j[1] ? zhi_s6 : zlo_s6;
		end
	end

	logic signed [RESW-1:0] res_c [4];
	logic [3:0]             sat_c;
	logic signed [CW-1:0]   crd_c [4];
	always_comb begin
		logic signed [CW-1:0] s0;
		for (int j = 0; j < 4; j++) begin
			s0       = j[0] ? side_s8.s0y : side_s8.s0x;
			res_c[j] = RESW'(s0) + RESW'(t_s8[j] >>> RF);
			if (res_c[j] > $signed(RESW'({1'b0, {(CW-1){1'b1}}}))) begin
				sat_c[j] = 1'b1;
				crd_c[j] = {1'b0, {(CW-1){1'b1}}};
			end else if (res_c[j] < $signed(RESW'($signed({1'b1, {(CW-1){1'b0}}})))) begin
				sat_c[j] = 1'b1;
				crd_c[j] = {1'b1, {(CW-1){1'b0}}};
			end else begin
				sat_c[j] = 1'b0;
				crd_c[j] = CW'(res_c[j]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= div_vld;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	logic signed [CW-1:0] crd_s9 [4];
	logic [FLAG_W-1:0]    flag_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5 <= side_d_s[QB-1];
			z_s5    <= zc;

			side_s6 <= side_s5;
			zlo_s6  <= zlo_c;
			zhi_s6  <= zhi_c;

			side_s7 <= side_s6;
			for (int j = 0; j < 4; j++) begin
				pl_s7[j] <= vsel[j] * $signed({1'b0, zsel[j][ZL-1:0]});
				ph_s7[j] <= vsel[j] * $signed(zsel[j][ZW-1:ZL]);
			end

			side_s8 <= side_s7;
			for (int j = 0; j < 4; j++) begin
				t_s8[j] <= (TW'(ph_s7[j]) <<< ZL) + TW'(pl_s7[j])
					+ $signed(TW'(1) <<< (RF - 1));
			end

			if (side_s8.fused) begin
				crd_s9     <= crd_c;
				flag_s9[2] <= |sat_c;
			end else begin
				crd_s9[0]  <= side_s8.s0x;
				crd_s9[1]  <= side_s8.s0y;
				crd_s9[2]  <= side_s8.s1x;
				crd_s9[3]  <= side_s8.s1y;
				flag_s9[2] <= 1'b0;
			end
			flag_s9[0] <= side_s8.fused;
			flag_s9[1] <= side_s8.degen;
		end
	end

	assign m_axis_tvalid = vld_s9;
	assign m_axis_tuser  = flag_s9;
	assign m_axis_tdata  = ODW'({crd_s9[3], crd_s9[2], crd_s9[1], crd_s9[0]});

	a_fused_not_degen: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("fused and degenerate both set");

	a_sat_needs_fuse: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[0])
		else $error("saturated without fused");

	a_div_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		adv && div_vld |=> vld_s5)
		else $error("divider word lost between stages");

endmodule
